>>> hw/rtl/uart_rb_pkg.sv
// ----------------------------------------------------------------------------
// uart_rb_pkg
// Shared constants for the serial byte queue pair: default depth, widths, operation and result codes.
// ----------------------------------------------------------------------------
package uart_rb_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CODE_W = 4;

  // host and line operations
  localparam logic [OP_W-1:0] OP_WRITE    = 2'd0;
  localparam logic [OP_W-1:0] OP_READ     = 2'd1;
  localparam logic [OP_W-1:0] OP_LINE_RX  = 2'd2;
  localparam logic [OP_W-1:0] OP_TX_EVENT = 2'd3;

  // result codes
  localparam logic [CODE_W-1:0] RC_SENT_DIRECT = 4'd0;
  localparam logic [CODE_W-1:0] RC_QUEUED      = 4'd1;
  localparam logic [CODE_W-1:0] RC_TX_DROPPED  = 4'd2;
  localparam logic [CODE_W-1:0] RC_READ_OK     = 4'd3;
  localparam logic [CODE_W-1:0] RC_READ_EMPTY  = 4'd4;
  localparam logic [CODE_W-1:0] RC_RECEIVED    = 4'd5;
  localparam logic [CODE_W-1:0] RC_RX_DROPPED  = 4'd6;
  localparam logic [CODE_W-1:0] RC_SENT_QUEUED = 4'd7;
  localparam logic [CODE_W-1:0] RC_TX_IDLE     = 4'd8;

endpackage

>>> hw/rtl/uart_rx_tx_ring_buffers.sv
// Timing: a non-popping transaction's result is registered in the cycle after accept;
//   a popping transaction (host read with data, transmitter ready with data) first
//   waits in S_POP for the registered queue memory read. Throughput: one transaction
//   per cycle while no pop is in progress and the output register is not stalled.
// Reset: synchronous, clears the state, both queues' pointers and the output valid flag;
//   queue memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers
// Receive and transmit byte ring queues between a host and a serial line,
// with a direct path to the line when the transmit queue is empty and the line is ready.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers #(
  parameter int unsigned QUEUE_DEPTH = uart_rb_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [uart_rb_pkg::OP_W-1:0]       in_opcode,
  input  logic [uart_rb_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic                               in_tx_ready,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [uart_rb_pkg::CODE_W-1:0]     out_result_code,
  output logic                               out_line_valid,
  output logic [uart_rb_pkg::BYTE_W-1:0]     out_line_byte,
  output logic [uart_rb_pkg::BYTE_W-1:0]     out_read_byte
);
  import uart_rb_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t            state_r;
  logic [PTR_W-1:0]  rx_head_r, rx_tail_r, tx_head_r, tx_tail_r;
  logic              pend_tx_r;
  logic              out_valid_r;
  logic [CODE_W-1:0] out_code_r;
  logic              out_lvalid_r;
  logic [BYTE_W-1:0] out_lbyte_r;
  logic [BYTE_W-1:0] out_rbyte_r;

  logic [BYTE_W-1:0] rx_mem [QUEUE_DEPTH];
  logic [BYTE_W-1:0] tx_mem [QUEUE_DEPTH];
  logic [BYTE_W-1:0] rx_rd_r, tx_rd_r;

  logic              out_free;
  logic              accept;
  logic              rx_empty, rx_full, tx_empty, tx_full;
  logic [CODE_W-1:0] imm_code;
  logic              imm_lvalid;
  logic [BYTE_W-1:0] imm_lbyte;
  logic              go_pop, pop_tx;
  logic              rx_push, rx_pop, tx_push, tx_pop;

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // output register drains or is empty
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign rx_empty = (rx_head_r == rx_tail_r);
  assign tx_empty = (tx_head_r == tx_tail_r);
  assign rx_full  = (adv(rx_tail_r) == rx_head_r);
  assign tx_full  = (adv(tx_tail_r) == tx_head_r);

  always_comb begin
    imm_code   = RC_TX_IDLE;
    imm_lvalid = 1'b0;
    imm_lbyte  = '0;
    go_pop     = 1'b0;
    pop_tx     = 1'b0;
    rx_push    = 1'b0;
    rx_pop     = 1'b0;
    tx_push    = 1'b0;
    tx_pop     = 1'b0;
    unique case (in_opcode)
      OP_WRITE: begin
        if (tx_empty && in_tx_ready) begin
          imm_code   = RC_SENT_DIRECT;
          imm_lvalid = 1'b1;
          imm_lbyte  = in_data_byte;
        end else if (tx_full) begin
          imm_code = RC_TX_DROPPED;
        end else begin
          imm_code = RC_QUEUED;
          tx_push  = accept;
        end
      end
      OP_READ: begin
        if (!rx_empty) begin
          go_pop = 1'b1;
          rx_pop = accept;
        end else begin
          imm_code = RC_READ_EMPTY;
        end
      end
      OP_LINE_RX: begin
        if (rx_full) begin
          imm_code = RC_RX_DROPPED;
        end else begin
          imm_code = RC_RECEIVED;
          rx_push  = accept;
        end
      end
      OP_TX_EVENT: begin
        if (in_tx_ready && !tx_empty) begin
          go_pop = 1'b1;
          pop_tx = 1'b1;
          tx_pop = accept;
        end else begin
          imm_code = RC_TX_IDLE;
        end
      end
      default: begin
        imm_code = RC_TX_IDLE;
      end
    endcase
  end

  // queue memories: one write port at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (rx_push) begin
      rx_mem[rx_tail_r] <= in_data_byte;
    end
    if (rx_pop) begin
      rx_rd_r <= rx_mem[rx_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (tx_push) begin
      tx_mem[tx_tail_r] <= in_data_byte;
    end
    if (tx_pop) begin
      tx_rd_r <= tx_mem[tx_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      pend_tx_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rx_push) rx_tail_r <= adv(rx_tail_r);
      if (rx_pop)  rx_head_r <= adv(rx_head_r);
      if (tx_push) tx_tail_r <= adv(tx_tail_r);
      if (tx_pop)  tx_head_r <= adv(tx_head_r);
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (go_pop) begin
              state_r     <= S_POP;
              pend_tx_r   <= pop_tx;
              out_valid_r <= 1'b0;
            end else begin
              out_valid_r  <= 1'b1;
              out_code_r   <= imm_code;
              out_lvalid_r <= imm_lvalid;
              out_lbyte_r  <= imm_lbyte;
              out_rbyte_r  <= '0;
            end
          end else if (out_free) begin
            out_valid_r <= 1'b0;
          end
        end
        S_POP: begin
          // read data from the queue memory lands this cycle
          state_r      <= S_IDLE;
          out_valid_r  <= 1'b1;
          out_code_r   <= pend_tx_r ? RC_SENT_QUEUED : RC_READ_OK;
          out_lvalid_r <= pend_tx_r;
          out_lbyte_r  <= pend_tx_r ? tx_rd_r : '0;
          out_rbyte_r  <= pend_tx_r ? '0 : rx_rd_r;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_code = out_code_r;
  assign out_line_valid  = out_lvalid_r;
  assign out_line_byte   = out_lbyte_r;
  assign out_read_byte   = out_rbyte_r;

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    rx_head_r <= PTR_LAST && rx_tail_r <= PTR_LAST &&
    tx_head_r <= PTR_LAST && tx_tail_r <= PTR_LAST)
    else $error("queue pointer beyond depth");

  a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |-> !out_valid_r)
    else $error("pop result would overwrite a pending result");

  a_pop_seq: assert property (@(posedge clk) disable iff (!rst_n)
    accept && go_pop |=> state_r == S_POP && !out_valid_r)
    else $error("popping transaction did not wait for memory data");

  a_line_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_lvalid_r |->
      out_code_r == RC_SENT_DIRECT || out_code_r == RC_SENT_QUEUED)
    else $error("line byte sent with a non-send result code");

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    tx_full |=> !(tx_head_r == tx_tail_r && $past(tx_head_r) == tx_head_r))
    else $error("transmit queue wrapped on overflow");

endmodule
